>>> design/kpdm_pkg.sv
// Shared constants for the Klein to Poincare disc map.
`timescale 1ns / 1ps

package kpdm_pkg;

	// Default coordinate format: signed Q2.14.
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// Width of the inversion count carried with each pixel.
	localparam int CNT_W = 8;

endpackage

>>> design/kpdm_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
`timescale 1ns / 1ps

module kpdm_sqrt #(
	parameter int ROOT_W = 16,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [2*ROOT_W-1:0] in_val,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_vld,
	output logic [ROOT_W-1:0]   out_root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int REM_W = ROOT_W + 2;

	logic                vld_s  [1:ROOT_W];
	logic [2*ROOT_W-1:0] val_s  [1:ROOT_W];
	logic [REM_W-1:0]    rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];
	logic [SIDE_W-1:0]   side_s [1:ROOT_W];

	genvar k;
	generate
		for (k = 0; k < ROOT_W; k++) begin : g_stage
			logic                cur_vld;
			logic [2*ROOT_W-1:0] cur_val;
			logic [REM_W-1:0]    cur_rem;
			logic [ROOT_W-1:0]   cur_root;
			logic [SIDE_W-1:0]   cur_side;
			logic [REM_W-1:0]    trial;
			logic [REM_W-1:0]    test;

			if (k == 0) begin : g_first
				assign cur_vld  = in_vld;
				assign cur_val  = in_val;
				assign cur_rem  = '0;
				assign cur_root = '0;
				assign cur_side = in_side;
			end else begin : g_next
				assign cur_vld  = vld_s[k];
				assign cur_val  = val_s[k];
				assign cur_rem  = rem_s[k];
				assign cur_root = root_s[k];
				assign cur_side = side_s[k];
			end

			// Bring down the next two bits and try the next root bit.
			assign trial = {cur_rem[REM_W-3:0], cur_val[2*ROOT_W-1 -: 2]};
			assign test  = {cur_root, 2'b01};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= cur_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					val_s[k+1]  <= cur_val << 2;
					side_s[k+1] <= cur_side;
					if (trial >= test) begin
						rem_s[k+1]  <= trial - test;
						root_s[k+1] <= {cur_root[ROOT_W-2:0], 1'b1};
					end else begin
						rem_s[k+1]  <= trial;
						root_s[k+1] <= {cur_root[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[ROOT_W];
	assign out_root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

endmodule

>>> design/kpdm_div.sv
// Pipelined restoring divider, two numerators over one shared divisor.
`timescale 1ns / 1ps

module kpdm_div #(
	parameter int Q_W    = 14,
	parameter int D_W    = 17,
	parameter int N_W    = 30,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [N_W-1:0]    num_a,
	input  logic [N_W-1:0]    num_b,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [Q_W-1:0]    quo_a,
	output logic [Q_W-1:0]    quo_b,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [1:Q_W];
	logic [D_W-1:0]    den_s  [1:Q_W];
	logic [D_W-1:0]    rema_s [1:Q_W];
	logic [D_W-1:0]    remb_s [1:Q_W];
	logic [Q_W-1:0]    lowa_s [1:Q_W];
	logic [Q_W-1:0]    lowb_s [1:Q_W];
	logic [Q_W-1:0]    quoa_s [1:Q_W];
	logic [Q_W-1:0]    quob_s [1:Q_W];
	logic [SIDE_W-1:0] side_s [1:Q_W];

	genvar k;
	generate
		for (k = 0; k < Q_W; k++) begin : g_stage
			logic              cur_vld;
			logic [D_W-1:0]    cur_den;
			logic [D_W-1:0]    cur_rema;
			logic [D_W-1:0]    cur_remb;
			logic [Q_W-1:0]    cur_lowa;
			logic [Q_W-1:0]    cur_lowb;
			logic [Q_W-1:0]    cur_quoa;
			logic [Q_W-1:0]    cur_quob;
			logic [SIDE_W-1:0] cur_side;
			logic [D_W:0]      trial_a;
			logic [D_W:0]      trial_b;
			logic [D_W:0]      den_x;
			logic              ge_a;
			logic              ge_b;

			if (k == 0) begin : g_first
				// The upper numerator bits are below the divisor, since the
				// quotient fits in Q_W bits.
				assign cur_vld  = in_vld;
				assign cur_den  = den;
				assign cur_rema = D_W'(num_a[N_W-1:Q_W]);
				assign cur_remb = D_W'(num_b[N_W-1:Q_W]);
				assign cur_lowa = num_a[Q_W-1:0];
				assign cur_lowb = num_b[Q_W-1:0];
				assign cur_quoa = '0;
				assign cur_quob = '0;
				assign cur_side = in_side;
			end else begin : g_next
				assign cur_vld  = vld_s[k];
				assign cur_den  = den_s[k];
				assign cur_rema = rema_s[k];
				assign cur_remb = remb_s[k];
				assign cur_lowa = lowa_s[k];
				assign cur_lowb = lowb_s[k];
				assign cur_quoa = quoa_s[k];
				assign cur_quob = quob_s[k];
				assign cur_side = side_s[k];
			end

			assign trial_a = {cur_rema, cur_lowa[Q_W-1]};
			assign trial_b = {cur_remb, cur_lowb[Q_W-1]};
			assign den_x   = {1'b0, cur_den};
			assign ge_a    = trial_a >= den_x;
			assign ge_b    = trial_b >= den_x;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (en) begin
					vld_s[k+1] <= cur_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k+1]  <= cur_den;
					side_s[k+1] <= cur_side;
					lowa_s[k+1] <= cur_lowa << 1;
					lowb_s[k+1] <= cur_lowb << 1;
					quoa_s[k+1] <= {cur_quoa[Q_W-2:0], ge_a};
					quob_s[k+1] <= {cur_quob[Q_W-2:0], ge_b};
					rema_s[k+1] <= ge_a ? D_W'(trial_a - den_x) : trial_a[D_W-1:0];
					remb_s[k+1] <= ge_b ? D_W'(trial_b - den_x) : trial_b[D_W-1:0];
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[Q_W];
	assign quo_a    = quoa_s[Q_W];
	assign quo_b    = quob_s[Q_W];
	assign out_side = side_s[Q_W];

endmodule

>>> design/klein_to_poincare_disc_map.sv
// Top level of the Klein to Poincare disc map pipeline.
`timescale 1ns / 1ps

// Maps one pixel map entry per item from the Klein disc to the Poincare disc.
// The input channel (in_valid, in_stall) carries x_in and y_in in signed
// fixed point, an inversion count and a pixel valid flag. The output channel
// (out_valid, out_stall) returns one result item for every input item, in
// order. A valid point strictly inside the unit disc is scaled by
// 1/(1+sqrt(1-x^2-y^2)) with rounding to nearest; every other item comes
// back with result_valid low and all other fields zero.
// The pipeline is 2*FRAC_BITS+7 register stages deep, with FRAC_BITS = 14
// in the default Q2.14 format. The square root stages (one root bit each)
// and the divider stages (one quotient bit each) make up most of that
// depth. A new item is accepted in every cycle in which the output is not
// stalled, so the sustained rate is one item per clock. The whole pipeline
// advances together whenever the output register is empty or its item is
// being taken. While the receiver stalls a held result, in_stall is
// raised, every stage holds, and nothing is lost or repeated. Reset clears
// all stage valid bits, so the block starts empty and keeps no other state.
module klein_to_poincare_disc_map #(
	parameter int COORD_BITS = kpdm_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = kpdm_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_in,
	input  logic signed [COORD_BITS-1:0] y_in,
	input  logic [kpdm_pkg::CNT_W-1:0]   inversion_count,
	input  logic                         pixel_valid,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] x_out,
	output logic signed [COORD_BITS-1:0] y_out,
	output logic [kpdm_pkg::CNT_W-1:0]   inversion_out,
	output logic                         result_valid
);

	localparam int C      = COORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int CW     = kpdm_pkg::CNT_W;
	localparam int SQ_W   = 2 * C;
	localparam int D_W    = 2 * F + 1;
	localparam int ROOT_W = F + 2;
	localparam int DEN_W  = F + 3;
	localparam int NUM_W  = 2 * F + 2;
	localparam int SIDE_W = 3 + CW;
	localparam int SQS_W  = SIDE_W + 2 * F;

	localparam logic [SQ_W-1:0]  ONE_SQ  = SQ_W'(1) << (2 * F);
	localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << (F + 1);

	logic en;

	// The pipeline moves as one whenever the output register can take an item.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// Stage 1: magnitudes and signs.
	logic            vld_s1;
	logic [C-1:0]    ax_s1;
	logic [C-1:0]    ay_s1;
	logic            sx_s1;
	logic            sy_s1;
	logic [CW-1:0]   cnt_s1;
	logic            pv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= x_in[C-1];
			sy_s1  <= y_in[C-1];
			ax_s1  <= x_in[C-1] ? C'(-x_in) : C'(x_in);
			ay_s1  <= y_in[C-1] ? C'(-y_in) : C'(y_in);
			cnt_s1 <= inversion_count;
			pv_s1  <= pixel_valid;
		end
	end

	// Stage 2: squares.
	logic            vld_s2;
	logic [SQ_W-1:0] sqx_s2;
	logic [SQ_W-1:0] sqy_s2;
	logic [C-1:0]    ax_s2;
	logic [C-1:0]    ay_s2;
	logic            sx_s2;
	logic            sy_s2;
	logic [CW-1:0]   cnt_s2;
	logic            pv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			cnt_s2 <= cnt_s1;
			pv_s2  <= pv_s1;
		end
	end

	// Stage 3: radius test and 1 - x^2 - y^2. Each square is at most
	// 2^(2C-2), so the sum cannot overflow.
	logic [SQ_W-1:0] sum_c;
	logic            vld_s3;
	logic            disc_s3;
	logic [D_W-1:0]  d_s3;
	logic [F-1:0]    mx_s3;
	logic [F-1:0]    my_s3;
	logic            sx_s3;
	logic            sy_s3;
	logic [CW-1:0]   cnt_s3;

	assign sum_c = sqx_s2 + sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s3 <= pv_s2 && (sum_c < ONE_SQ);
			d_s3    <= D_W'(ONE_SQ - sum_c);
			mx_s3   <= ax_s2[F-1:0];
			my_s3   <= ay_s2[F-1:0];
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			cnt_s3  <= cnt_s2;
		end
	end

	// Square root of 4*d, carrying the rest of the item alongside.
	logic                sq_vld;
	logic [ROOT_W-1:0]   sq_root;
	logic [SQS_W-1:0]    sq_side;
	logic [2*ROOT_W-1:0] sq_val;

	assign sq_val = {1'b0, d_s3, 2'b00};

	kpdm_sqrt #(
		.ROOT_W (ROOT_W),
		.SIDE_W (SQS_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_val   (sq_val),
		.in_side  ({disc_s3, sx_s3, sy_s3, cnt_s3, mx_s3, my_s3}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// Stage 4: denominator and rounded numerators.
	logic [DEN_W-1:0]  den_c;
	logic [F-1:0]      sq_mx;
	logic [F-1:0]      sq_my;
	logic              vld_s4;
	logic [DEN_W-1:0]  den_s4;
	logic [NUM_W-1:0]  numx_s4;
	logic [NUM_W-1:0]  numy_s4;
	logic [SIDE_W-1:0] side_s4;

	assign den_c = DEN_ONE + DEN_W'(sq_root);
	assign sq_mx = sq_side[2*F-1:F];
	assign sq_my = sq_side[F-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4  <= den_c;
			numx_s4 <= NUM_W'({sq_mx, {(F+1){1'b0}}}) + NUM_W'(den_c >> 1);
			numy_s4 <= NUM_W'({sq_my, {(F+1){1'b0}}}) + NUM_W'(den_c >> 1);
			side_s4 <= sq_side[SQS_W-1:2*F];
		end
	end

	// The quotient never exceeds the input magnitude, so F bits suffice.
	logic              dv_vld;
	logic [F-1:0]      dv_qx;
	logic [F-1:0]      dv_qy;
	logic [SIDE_W-1:0] dv_side;

	kpdm_div #(
		.Q_W    (F),
		.D_W    (DEN_W),
		.N_W    (NUM_W),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num_a    (numx_s4),
		.num_b    (numy_s4),
		.den      (den_s4),
		.in_side  (side_s4),
		.out_vld  (dv_vld),
		.quo_a    (dv_qx),
		.quo_b    (dv_qy),
		.out_side (dv_side)
	);

	// Output register: restore signs and zero everything outside the disc.
	logic          dv_disc;
	logic          dv_sx;
	logic          dv_sy;
	logic [CW-1:0] dv_cnt;
	logic [C-1:0]  magx;
	logic [C-1:0]  magy;

	assign dv_disc = dv_side[SIDE_W-1];
	assign dv_sx   = dv_side[SIDE_W-2];
	assign dv_sy   = dv_side[SIDE_W-3];
	assign dv_cnt  = dv_side[CW-1:0];
	assign magx    = C'(dv_qx);
	assign magy    = C'(dv_qy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_valid  <= dv_disc;
			x_out         <= dv_disc ? (dv_sx ? -magx : magx) : '0;
			y_out         <= dv_disc ? (dv_sy ? -magy : magy) : '0;
			inversion_out <= dv_disc ? dv_cnt : '0;
		end
	end

	// An invalid result always carries zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_valid |-> x_out == '0 && y_out == '0 && inversion_out == '0)
		else $error("invalid result with nonzero fields");

	// The input is held back exactly when a result waits on a stalled receiver.
	a_stall_map: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	// A stalled result is not dropped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result lost");

	// Scaling cannot reach the most negative code.
	a_no_minval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_valid |-> x_out != {1'b1, {(C-1){1'b0}}}
			&& y_out != {1'b1, {(C-1){1'b0}}})
		else $error("mapped coordinate out of range");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the Klein to Poincare disc map pipeline.
`timescale 1ns / 1ps

// Pixel map entries are queued by an initial block and fed to the block by a
// clocked driver. For each accepted item the expected disc mapping is worked
// out in integer arithmetic and pushed on a queue of expected results. A
// clocked monitor takes each result item and compares it field by field with
// the oldest expected result. The block keeps no state beyond its pipeline
// registers, so the run is one stream of directed entries followed by
// random ones, split into idling phases.
module testbench;

	localparam int CW = kpdm_pkg::COORD_BITS_DEF;
	localparam int FW = kpdm_pkg::FRAC_BITS_DEF;
	localparam int NW = kpdm_pkg::CNT_W;
	// The pipeline is 2*FRAC_BITS+7 stages deep.
	localparam int DEPTH = 2 * FW + 7;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [NW-1:0]        cnt;
		logic                 pv;
	} pixel_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [NW-1:0]        cnt;
		logic                 ok;
	} mapped_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] x_in = '0;
	logic signed [CW-1:0] y_in = '0;
	logic [NW-1:0] inversion_count = '0;
	logic pixel_valid = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] x_out;
	logic signed [CW-1:0] y_out;
	logic [NW-1:0] inversion_out;
	logic result_valid;

	pixel_t pending_pixels[$];
	mapped_t expected_maps[$];
	int mismatches = 0;
	int cycles = 0;
	// Idle rates in percent; the initial block moves them between phases.
	int send_idle_pct = 10;
	int recv_idle_pct = 79;
	// Long receiver hold-off, counted down in the stall process.
	int hold_cycles = 0;
	// Sender pause request until everything has drained.
	bit drain_pause = 1'b0;

	klein_to_poincare_disc_map i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.x_in(x_in), .y_in(y_in),
		.inversion_count(inversion_count), .pixel_valid(pixel_valid),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_out(x_out), .y_out(y_out),
		.inversion_out(inversion_out), .result_valid(result_valid)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Integer square root, floor, by the digit-by-digit method.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Divides one coordinate by the denominator, rounding to nearest with ties
	// away from zero; the sign of the input is applied to the magnitude.
	function automatic logic signed [CW-1:0] shrink_coord(longint c,
			longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (c < 0) ? longint'(-c) : longint'(c);
		q = ((mag << (FW + 1)) + (den >> 1)) / den;
		return (c < 0) ? CW'(-longint'(q)) : CW'(q);
	endfunction

	function automatic mapped_t klein_to_poincare(pixel_t p);
		mapped_t m;
		longint sx;
		longint sy;
		longint unsigned one2;
		longint unsigned r2;
		longint unsigned den;
		sx = p.x;
		sy = p.y;
		one2 = 64'd1 << (2 * FW);
		r2 = sx * sx + sy * sy;
		m = '0;
		// Invalid entries and points on or outside the rim give an empty result.
		if (p.pv && r2 < one2) begin
			den = (64'd1 << (FW + 1)) + floor_sqrt((one2 - r2) << 2);
			m.x = shrink_coord(sx, den);
			m.y = shrink_coord(sy, den);
			m.cnt = p.cnt;
			m.ok = 1'b1;
		end
		return m;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d at cycle %0d",
			what, got, want, cycles);
		mismatches++;
	endtask

	// Random entry: mostly points inside the disc, with some on the rim,
	// some outside, some with the valid flag low and some fully random.
	function automatic pixel_t random_pixel();
		pixel_t p;
		int kind;
		int r;
		int a;
		kind = $urandom_range(0, 9);
		p.cnt = NW'($urandom);
		p.pv = ($urandom_range(0, 9) != 0);
		if (kind < 6) begin
			// Uniform inside a square that fits within the disc most of the time.
			p.x = CW'($urandom_range(0, 32767) - 16384);
			p.y = CW'($urandom_range(0, 32767) - 16384);
		end else if (kind < 8) begin
			// Near the rim: pick x, then y close to sqrt(1-x^2).
			a = $urandom_range(0, 16384);
			r = int'(floor_sqrt((64'd1 << 28) - longint'(a) * a));
			p.x = ($urandom_range(0, 1) != 0) ? CW'(-a) : CW'(a);
			r = r + $urandom_range(0, 2) - 1;
			if (r < 0) r = 0;
			p.y = ($urandom_range(0, 1) != 0) ? CW'(-r) : CW'(r);
		end else begin
			p.x = CW'($urandom);
			p.y = CW'($urandom);
		end
		return p;
	endfunction

	// Driver: offers the head of the pending queue; advances on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_maps.push_back(klein_to_poincare(pending_pixels.pop_front()));
			end
			// Valid is only lowered when the current item was taken or none is up.
			if (!in_valid || !in_stall) begin
				if (pending_pixels.size() > 0 && !drain_pause
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					x_in <= pending_pixels[0].x;
					y_in <= pending_pixels[0].y;
					inversion_count <= pending_pixels[0].cnt;
					pixel_valid <= pending_pixels[0].pv;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Pending queue holds the item on the bus at its head, so pop after accept.
	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		mapped_t want;
		if (arst_n) begin
			cycles++;
			if (out_valid && !out_stall) begin
				if (expected_maps.size() == 0) begin
					report_mismatch("result count", 1, 0);
				end else begin
					want = expected_maps.pop_front();
					if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
					if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
					if (inversion_out !== want.cnt)
						report_mismatch("inversion_out", inversion_out, want.cnt);
					if (result_valid !== want.ok)
						report_mismatch("result_valid", result_valid, want.ok);
				end
			end
			if (cycles >= CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver stall, with the long hold-off counted down here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic wait_drained();
		while (pending_pixels.size() > 0 || in_valid || expected_maps.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_random(int n);
		repeat (n) pending_pixels.push_back(random_pixel());
	endtask

	function automatic pixel_t mk(int x, int y, int c, bit v);
		pixel_t p;
		p.x = CW'(x);
		p.y = CW'(y);
		p.cnt = NW'(c);
		p.pv = v;
		return p;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: origin, field extremes, the rim, just inside it, the most
		// negative coordinate, and invalid pixels.
		pending_pixels.push_back(mk(0, 0, 0, 1));
		pending_pixels.push_back(mk(0, 0, 255, 1));
		pending_pixels.push_back(mk(16383, 0, 170, 1));
		pending_pixels.push_back(mk(-16383, 0, 85, 1));
		pending_pixels.push_back(mk(0, 16383, 1, 1));
		pending_pixels.push_back(mk(0, -16383, 128, 1));
		pending_pixels.push_back(mk(16384, 0, 7, 1));
		pending_pixels.push_back(mk(0, -16384, 7, 1));
		pending_pixels.push_back(mk(11585, 11585, 9, 1));
		pending_pixels.push_back(mk(11584, -11584, 9, 1));
		pending_pixels.push_back(mk(-32768, 0, 3, 1));
		pending_pixels.push_back(mk(0, -32768, 3, 1));
		pending_pixels.push_back(mk(-32768, -32768, 255, 1));
		pending_pixels.push_back(mk(32767, 32767, 255, 1));
		pending_pixels.push_back(mk(1, -1, 255, 1));
		pending_pixels.push_back(mk(-1, 1, 0, 1));
		pending_pixels.push_back(mk(100, 200, 42, 0));
		pending_pixels.push_back(mk(0, 0, 255, 0));
		pending_pixels.push_back(mk(-32768, 32767, 255, 0));
		pending_pixels.push_back(mk(21845, -10923, 90, 1));
		add_random(630);
		wait_drained();

		// Second phase: sender idles often, receiver seldom. A long receiver
		// hold-off fills the pipeline while the sender keeps offering.
		send_idle_pct = 79;
		recv_idle_pct = 10;
		add_random(100);
		send_idle_pct = 0;
		hold_cycles = 3 * DEPTH;
		while (hold_cycles > 0) @(posedge clk);
		send_idle_pct = 79;
		add_random(550);
		wait_drained();

		// Sender pause: stop offering until every result is back.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(50);
		repeat (20) @(posedge clk);
		drain_pause = 1'b1;
		while (expected_maps.size() > 0 || in_valid) @(posedge clk);
		drain_pause = 1'b0;

		// Last phase: neither side idles.
		add_random(600);
		wait_drained();
		repeat (DEPTH + 10) @(posedge clk);

		if (mismatches == 0 && expected_maps.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
design/kpdm_pkg.sv
design/kpdm_sqrt.sv
design/kpdm_div.sv
design/klein_to_poincare_disc_map.sv
verif/testbench.sv
